>>> sv/sas_pkg.sv
package sas_pkg;

  localparam int unsigned DutyW   = 14;
  localparam int unsigned StepW   = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE    = 3'd0,
    MODE_DOWN    = 3'd1,
    MODE_MID     = 3'd2,
    MODE_UP      = 3'd3,
    MODE_MAG_OFF = 3'd4,
    MODE_MAG_ON  = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BACK_POS     = 3'd0,
    REG_MID_POS      = 3'd1,
    REG_FETCH_POS    = 3'd2,
    REG_STEP_ZERO    = 3'd3,
    REG_STEP_ONE     = 3'd4,
    REG_DUTY_MAX     = 3'd5,
    REG_DUTY_MIN     = 3'd6,
    REG_SETTLE_TICKS = 3'd7
  } cfg_reg_e;

  localparam logic [DutyW-1:0]  BackPosRst     = 14'd725;
  localparam logic [DutyW-1:0]  MidPosRst      = 14'd690;
  localparam logic [DutyW-1:0]  FetchPosRst    = 14'd665;
  localparam logic [StepW-1:0]  StepZeroRst    = 10'd10;
  localparam logic [StepW-1:0]  StepOneRst     = 10'd20;
  localparam logic [DutyW-1:0]  DutyMaxRst     = 14'd10000;
  localparam logic [DutyW-1:0]  DutyMinRst     = 14'd0;
  localparam logic [CountW-1:0] SettleTicksRst = 8'd15;

endpackage

>>> sv/servo_arm_sequencer_with_slew.sv
// Two-arm servo sequencer with per-arm slew-rate limiting.
// Input stream (s_axis_*): tuser = kind. kind 0 runs one control tick,
// kind 1 writes the command in tdata to the addressed arm (codes 6 and 7
// are dropped). Every input item yields exactly one output item.
// Output stream (m_axis_*): the arm state after the input item: duties,
// relays, done flags and command states of both arms.
// Config channel (cfg_*): register index and data, always ready; write
// only while no item is in flight.
// Output valid in the cycle after input accept. Throughput: one item per
// cycle while results are taken; the arm state registers double as the
// output register, so a new item is taken in the same cycle as the previous
// result is taken. Receiver stall: the result holds and s_axis_tready drops
// until it is taken. Reset: both arms idle at duty 725, done set, relays off,
// settle count zero, config registers at their default values.
module servo_arm_sequencer_with_slew (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] arm, [3:1] command, [7:4] zero
  input  logic [sas_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [13:0] duty_zero, [27:14] duty_one, [28] relay_zero, [29] relay_one,
  // [30] done_zero, [31] done_one, [34:32] mode_zero, [37:35] mode_one,
  // [39:38] zero
  output logic [sas_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sas_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned DW = sas_pkg::DutyW;

  logic [DW-1:0]                back_pos_q, mid_pos_q, fetch_pos_q, duty_max_q, duty_min_q;
  logic [sas_pkg::StepW-1:0]    step_zero_q, step_one_q;
  logic [sas_pkg::CountW-1:0]   settle_ticks_q;

  sas_pkg::mode_e               mode_q [2];
  sas_pkg::mode_e               mode_d [2];
  logic [DW-1:0]                tgt_q [2];
  logic [DW-1:0]                tgt_d [2];
  logic [DW-1:0]                cur_q [2];
  logic [DW-1:0]                cur_d [2];
  logic [1:0]                   done_q, done_d;
  logic [1:0]                   relay_q, relay_d;
  logic [sas_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                         m_valid_q;
  logic                         in_acc;

  function automatic logic [DW-1:0] clamp_duty(input logic signed [DW+1:0] v,
                                               input logic [DW-1:0] hi,
                                               input logic [DW-1:0] lo);
    logic [DW-1:0] r;
    if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else if (v < $signed({2'b00, lo})) begin
      r = lo;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, mode_q[1], mode_q[0], done_q[1], done_q[0],
                          relay_q[1], relay_q[0], cur_q[1], cur_q[0]};

  always_comb begin
    logic [DW-1:0]             req;
    logic [DW-1:0]             dreq;
    logic                      do_req;
    logic                      hit;
    logic signed [DW+1:0]      t, c, s, diff;
    logic [sas_pkg::ModeW-1:0] cmd;
    mode_d  = mode_q;
    tgt_d   = tgt_q;
    cur_d   = cur_q;
    done_d  = done_q;
    relay_d = relay_q;
    cnt_d   = cnt_q;
    req     = back_pos_q;
    dreq    = back_pos_q;
    do_req  = 1'b0;
    hit     = 1'b0;
    t       = '0;
    c       = '0;
    s       = '0;
    diff    = '0;
    cmd     = s_axis_tdata[3:1];
    if (s_axis_tuser) begin
      if (cmd <= sas_pkg::MODE_MAG_ON) begin
        mode_d[s_axis_tdata[0]] = sas_pkg::mode_e'(cmd);
      end
    end else begin
      for (int ch = 0; ch < 2; ch++) begin
        req    = back_pos_q;
        do_req = 1'b0;
        case (mode_d[1'(ch)])
          sas_pkg::MODE_DOWN: begin
            do_req = 1'b1;
            req    = (ch == 0) ? fetch_pos_q : back_pos_q;
          end
          sas_pkg::MODE_MID: begin
            do_req = (ch == 1);
            req    = mid_pos_q;
          end
          sas_pkg::MODE_UP: begin
            do_req = 1'b1;
            req    = (ch == 0) ? back_pos_q : fetch_pos_q;
          end
          default: begin
            do_req = 1'b0;
          end
        endcase
        dreq = clamp_duty($signed({2'b00, req}), duty_max_q, duty_min_q);
        if (do_req && dreq != tgt_d[1'(ch)]) begin
          tgt_d[1'(ch)]  = dreq;
          done_d[1'(ch)] = 1'b0;
        end
        case (mode_d[1'(ch)])
          sas_pkg::MODE_DOWN: begin
            if (done_d[1'(ch)]) begin
              relay_d[1'(ch)] = 1'b1;
              cnt_d = cnt_d + 8'd1;
              hit   = (cnt_d >= settle_ticks_q);
              if (hit) begin
                cnt_d = '0;
                if (ch == 0) begin
                  mode_d[1'(ch)] = sas_pkg::MODE_UP;
                end
              end
            end
          end
          sas_pkg::MODE_MID: begin
            if (ch == 1 && done_d[1'(ch)]) begin
              mode_d[1'(ch)] = sas_pkg::MODE_IDLE;
            end
          end
          sas_pkg::MODE_UP: begin
            if (done_d[1'(ch)]) begin
              mode_d[1'(ch)] = sas_pkg::MODE_IDLE;
            end
          end
          sas_pkg::MODE_MAG_OFF: begin
            relay_d[1'(ch)] = 1'b0;
            mode_d[1'(ch)]  = sas_pkg::MODE_IDLE;
          end
          sas_pkg::MODE_MAG_ON: begin
            relay_d[1'(ch)] = 1'b1;
            mode_d[1'(ch)]  = sas_pkg::MODE_IDLE;
          end
          default: begin
          end
        endcase
      end
      for (int ch = 0; ch < 2; ch++) begin
        t = $signed({2'b00, tgt_d[1'(ch)]});
        c = $signed({2'b00, cur_d[1'(ch)]});
        s = $signed({6'd0, (ch == 0) ? step_zero_q : step_one_q});
        if (t == c) begin
          done_d[1'(ch)] = 1'b1;
        end
        if (t > c) begin
          c = c + s;
        end else if (t < c) begin
          c = c - s;
        end
        diff = t - c;
        if (diff < 0) begin
          diff = -diff;
        end
        if (diff <= s) begin
          c = t;
        end
        cur_d[1'(ch)] = clamp_duty(c, duty_max_q, duty_min_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_pos_q     <= sas_pkg::BackPosRst;
      mid_pos_q      <= sas_pkg::MidPosRst;
      fetch_pos_q    <= sas_pkg::FetchPosRst;
      step_zero_q    <= sas_pkg::StepZeroRst;
      step_one_q     <= sas_pkg::StepOneRst;
      duty_max_q     <= sas_pkg::DutyMaxRst;
      duty_min_q     <= sas_pkg::DutyMinRst;
      settle_ticks_q <= sas_pkg::SettleTicksRst;
    end else if (cfg_valid_i) begin
      case (sas_pkg::cfg_reg_e'(cfg_index_i))
        sas_pkg::REG_BACK_POS:     back_pos_q     <= cfg_data_i;
        sas_pkg::REG_MID_POS:      mid_pos_q      <= cfg_data_i;
        sas_pkg::REG_FETCH_POS:    fetch_pos_q    <= cfg_data_i;
        sas_pkg::REG_STEP_ZERO:    step_zero_q    <= cfg_data_i[sas_pkg::StepW-1:0];
        sas_pkg::REG_STEP_ONE:     step_one_q     <= cfg_data_i[sas_pkg::StepW-1:0];
        sas_pkg::REG_DUTY_MAX:     duty_max_q     <= cfg_data_i;
        sas_pkg::REG_DUTY_MIN:     duty_min_q     <= cfg_data_i;
        sas_pkg::REG_SETTLE_TICKS: settle_ticks_q <= cfg_data_i[sas_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '{sas_pkg::MODE_IDLE, sas_pkg::MODE_IDLE};
      tgt_q     <= '{sas_pkg::BackPosRst, sas_pkg::BackPosRst};
      cur_q     <= '{sas_pkg::BackPosRst, sas_pkg::BackPosRst};
      done_q    <= 2'b11;
      relay_q   <= 2'b00;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        tgt_q   <= tgt_d;
        cur_q   <= cur_d;
        done_q  <= done_d;
        relay_q <= relay_d;
        cnt_q   <= cnt_d;
      end
      if (in_acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> sv/sas_checker.sv
module sas_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sas_pkg::OutDataW-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready)
    |=> !m_axis_tvalid)
    else $error("result repeated without a new item");

endmodule

bind servo_arm_sequencer_with_slew sas_checker u_sas_checker (.*);
